// ===== rtl/cpr_pkg.sv =====
// shared types, constants and arctangent table for the polar/rectangular converter
package cpr_pkg;

  localparam int CORDIC_W  = 36;
  localparam int GUARD     = 14;
  localparam int ANG_SHIFT = 17;
  localparam int TABLE_LEN = 24;
  localparam int PROD_W    = 62;

  typedef logic signed [CORDIC_W-1:0] cord_t;

  localparam logic [29:0]        GAIN_Q30    = 30'h26DD3B6A;
  localparam cord_t              PI_Q30      = 36'sh0C90FDAA2;
  localparam cord_t              HALF_PI_Q30 = 36'sh06487ED51;
  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam cord_t              RND_Q12     = 36'sd8192;
  localparam cord_t              RND_ANG     = 36'sd65536;
  localparam logic [PROD_W:0]    RND_MAG     = (63'd1 << 43);

  typedef enum logic {
    KIND_TO_POLAR = 1'b0,
    KIND_TO_RECT  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  zero;
    logic  flip;
    cord_t x;
    cord_t y;
    cord_t z;
  } cord_stage_t;

  typedef struct packed {
    kind_t               kind;
    logic                zero;
    logic [PROD_W-1:0]   prod;
    logic signed [15:0]  ang;
    logic signed [16:0]  re;
    logic signed [16:0]  im;
    logic                csat;
  } post_stage_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic cord_t atan_q30(input logic [4:0] idx);
    cord_t r;
    unique case (idx)
      5'd0:    r = 36'sh03243F6A8;
      5'd1:    r = 36'sh01DAC6705;
      5'd2:    r = 36'sh00FADBAFC;
      5'd3:    r = 36'sh007F56EA6;
      5'd4:    r = 36'sh003FEAB76;
      5'd5:    r = 36'sh001FFD55B;
      5'd6:    r = 36'sh000FFFAAA;
      5'd7:    r = 36'sh0007FFF55;
      5'd8:    r = 36'sh0003FFFEA;
      5'd9:    r = 36'sh0001FFFFD;
      5'd10:   r = 36'sh0000FFFFF;
      5'd11:   r = 36'sh00007FFFF;
      5'd12:   r = 36'sh00003FFFF;
      5'd13:   r = 36'sh00001FFFF;
      5'd14:   r = 36'sh00000FFFF;
      5'd15:   r = 36'sh000007FFF;
      5'd16:   r = 36'sh000003FFF;
      5'd17:   r = 36'sh000001FFF;
      5'd18:   r = 36'sh000000FFF;
      5'd19:   r = 36'sh0000007FF;
      5'd20:   r = 36'sh0000003FF;
      5'd21:   r = 36'sh0000001FF;
      5'd22:   r = 36'sh0000000FF;
      5'd23:   r = 36'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one circular rotation; sh is a constant at every call site
  function automatic cord_stage_t cord_iter(input cord_stage_t s, input logic [4:0] sh);
    cord_stage_t r;
    cord_t       dx;
    cord_t       dy;
    cord_t       at;
    logic        neg;
    r   = s;
    dx  = $signed(s.y) >>> sh;
    dy  = $signed(s.x) >>> sh;
    at  = atan_q30(sh);
    // vectoring drives y to zero, rotation drives z to zero
    neg = (s.kind == KIND_TO_RECT) ? !s.z[CORDIC_W-1] : s.y[CORDIC_W-1];
    if (neg) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - at;
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + at;
    end
    return r;
  endfunction

endpackage

// ===== rtl/complex_polar_rect_converter.sv =====
// rectangular/polar complex converter, unrolled cordic pipeline
//
// Input channel: in_valid/in_stall with in_kind selecting the direction.
// Kind 0 takes in_real_part/in_imag_part (signed Q4.12) and returns
// out_magnitude_out (Q4.12, clamped, out_saturated set) and out_angle_out
// (atan2, signed Q3.13 radians). Kind 1 takes in_magnitude/in_angle and
// returns out_real_out/out_imag_out, clamped with out_saturated set.
// Fields not used by the kind come out as zero.
// Throughput: one transfer per cycle on each side while the output is not stalled.
// Stages: one prepare stage with the gain multiply, one stage per rotation step,
// one stage for the output multiply and rounding, one output register.
// Steps beyond 24 act as 24.
// When out_valid is high and out_stall is high the whole pipeline holds
// and in_stall is raised; no item is lost or repeated.
// Reset clears every valid bit; the datapath needs no reset.
module complex_polar_rect_converter #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic signed [16:0] in_real_part,
  input  logic signed [16:0] in_imag_part,
  input  logic        [15:0] in_magnitude,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_real_out,
  output logic signed [16:0] out_imag_out,
  output logic        [15:0] out_magnitude_out,
  output logic signed [15:0] out_angle_out,
  output logic               out_saturated
);

  localparam int NSTEPS = (ROTATION_STEPS > cpr_pkg::TABLE_LEN) ?
                          cpr_pkg::TABLE_LEN : ROTATION_STEPS;
  localparam int MSB    = cpr_pkg::CORDIC_W - 1;

  logic en;

  logic [NSTEPS:0]          cv_r;
  logic                     a_valid_r;
  logic                     out_valid_r;

  cpr_pkg::cord_stage_t     st_r   [NSTEPS+1];
  cpr_pkg::cord_stage_t     st_nxt [NSTEPS+1];
  cpr_pkg::cord_stage_t     prep_nxt;

  cpr_pkg::post_stage_t     a_r;
  cpr_pkg::post_stage_t     a_nxt;

  logic signed [16:0]       out_real_r,  out_real_nxt;
  logic signed [16:0]       out_imag_r,  out_imag_nxt;
  logic        [15:0]       out_mag_r,   out_mag_nxt;
  logic signed [15:0]       out_ang_r,   out_ang_nxt;
  logic                     out_sat_r,   out_sat_nxt;

  // whole pipeline moves unless the output register is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // prepare stage: quadrant fold and gain pre-scale
  cpr_pkg::cord_t re_s;
  cpr_pkg::cord_t im_s;
  cpr_pkg::cord_t ang_z;
  cpr_pkg::cord_t mag_x;
  logic [45:0]    mag_prod;

  always_comb begin
    re_s     = cpr_pkg::cord_t'(in_real_part) <<< cpr_pkg::GUARD;
    im_s     = cpr_pkg::cord_t'(in_imag_part) <<< cpr_pkg::GUARD;
    ang_z    = cpr_pkg::cord_t'(in_angle) <<< cpr_pkg::ANG_SHIFT;
    mag_prod = 46'(in_magnitude) * 46'(cpr_pkg::GAIN_Q30);
    mag_x    = cpr_pkg::cord_t'(mag_prod[45:16]);

    prep_nxt      = '0;
    prep_nxt.kind = cpr_pkg::kind_t'(in_kind);
    if (prep_nxt.kind == cpr_pkg::KIND_TO_POLAR) begin
      prep_nxt.zero = (in_real_part == '0) && (in_imag_part == '0);
      if (in_real_part[16]) begin
        // left half plane: negate and start from +-pi
        prep_nxt.x = -re_s;
        prep_nxt.y = -im_s;
        prep_nxt.z = in_imag_part[16] ? -cpr_pkg::PI_Q30 : cpr_pkg::PI_Q30;
      end else begin
        prep_nxt.x = re_s;
        prep_nxt.y = im_s;
      end
    end else begin
      prep_nxt.x = mag_x;
      priority if (ang_z > cpr_pkg::HALF_PI_Q30) begin
        prep_nxt.z    = ang_z - cpr_pkg::PI_Q30;
        prep_nxt.flip = 1'b1;
      end else if (ang_z < -cpr_pkg::HALF_PI_Q30) begin
        prep_nxt.z    = ang_z + cpr_pkg::PI_Q30;
        prep_nxt.flip = 1'b1;
      end else begin
        prep_nxt.z    = ang_z;
      end
    end
  end

  assign st_nxt[0] = prep_nxt;

  for (genvar g = 0; g < NSTEPS; g++) begin : g_rot
    assign st_nxt[g+1] = cpr_pkg::cord_iter(st_r[g], 5'(g));
  end

  // post stage: gain multiply for magnitude, rounding of angle and components
  cpr_pkg::cord_stage_t fin;
  logic [31:0]          xpos;
  cpr_pkg::cord_t       ang_sum;
  logic signed [18:0]   ang_w;
  cpr_pkg::cord_t       re_sum;
  cpr_pkg::cord_t       im_sum;
  logic signed [22:0]   re_w;
  logic signed [22:0]   im_w;
  logic                 re_sat;
  logic                 im_sat;

  always_comb begin
    fin     = st_r[NSTEPS];
    xpos    = fin.x[MSB] ? '0 : fin.x[31:0];
    ang_sum = fin.z + cpr_pkg::RND_ANG;
    ang_w   = $signed(ang_sum[MSB:cpr_pkg::ANG_SHIFT]);
    re_sum  = fin.x + cpr_pkg::RND_Q12;
    im_sum  = fin.y + cpr_pkg::RND_Q12;
    re_w    = 23'($signed(re_sum[MSB:cpr_pkg::GUARD]));
    im_w    = 23'($signed(im_sum[MSB:cpr_pkg::GUARD]));
    if (fin.flip) begin
      re_w = -re_w;
      im_w = -im_w;
    end

    a_nxt      = '0;
    a_nxt.kind = fin.kind;
    a_nxt.zero = fin.zero;
    a_nxt.prod = cpr_pkg::PROD_W'(xpos) * cpr_pkg::PROD_W'(cpr_pkg::GAIN_Q30);

    priority if (ang_w > 19'(cpr_pkg::PI_Q13)) begin
      a_nxt.ang = cpr_pkg::PI_Q13;
    end else if (ang_w < -19'(cpr_pkg::PI_Q13)) begin
      a_nxt.ang = -cpr_pkg::PI_Q13;
    end else begin
      a_nxt.ang = 16'(ang_w);
    end

    re_sat = 1'b0;
    im_sat = 1'b0;
    priority if (re_w > 23'sd65535) begin
      a_nxt.re = 17'sd65535;
      re_sat   = 1'b1;
    end else if (re_w < -23'sd65536) begin
      a_nxt.re = -17'sd65536;
      re_sat   = 1'b1;
    end else begin
      a_nxt.re = 17'(re_w);
    end
    priority if (im_w > 23'sd65535) begin
      a_nxt.im = 17'sd65535;
      im_sat   = 1'b1;
    end else if (im_w < -23'sd65536) begin
      a_nxt.im = -17'sd65536;
      im_sat   = 1'b1;
    end else begin
      a_nxt.im = 17'(im_w);
    end
    a_nxt.csat = re_sat || im_sat;
  end

  // output stage: magnitude rounding, saturation and field selection
  logic [cpr_pkg::PROD_W:0] mag_sum;
  logic [18:0]              mag_q;
  logic                     mag_sat;

  always_comb begin
    mag_sum = (cpr_pkg::PROD_W+1)'(a_r.prod) + cpr_pkg::RND_MAG;
    mag_q   = mag_sum[cpr_pkg::PROD_W:44];
    mag_sat = (mag_q > 19'd65535);

    out_real_nxt = '0;
    out_imag_nxt = '0;
    out_mag_nxt  = '0;
    out_ang_nxt  = '0;
    out_sat_nxt  = 1'b0;
    unique case (a_r.kind)
      cpr_pkg::KIND_TO_POLAR: begin
        if (!a_r.zero) begin
          out_mag_nxt = mag_sat ? 16'hFFFF : mag_q[15:0];
          out_ang_nxt = a_r.ang;
          out_sat_nxt = mag_sat;
        end
      end
      cpr_pkg::KIND_TO_RECT: begin
        out_real_nxt = a_r.re;
        out_imag_nxt = a_r.im;
        out_sat_nxt  = a_r.csat;
      end
      default: begin
        out_sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r        <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      cv_r        <= {cv_r[NSTEPS-1:0], in_valid};
      a_valid_r   <= cv_r[NSTEPS];
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r       <= st_nxt;
      a_r        <= a_nxt;
      out_real_r <= out_real_nxt;
      out_imag_r <= out_imag_nxt;
      out_mag_r  <= out_mag_nxt;
      out_ang_r  <= out_ang_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_real_out      = out_real_r;
  assign out_imag_out      = out_imag_r;
  assign out_magnitude_out = out_mag_r;
  assign out_angle_out     = out_ang_r;
  assign out_saturated     = out_sat_r;

endmodule

// ===== rtl/cpr_checker.sv =====
// port-level checks for the polar/rectangular converter, bound to the top level
module cpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [16:0] out_real_out,
  input logic signed [16:0] out_imag_out,
  input logic        [15:0] out_magnitude_out,
  input logic signed [15:0] out_angle_out,
  input logic               out_saturated
);

  // the input side only waits on a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_real_out) &&
      $stable(out_imag_out) && $stable(out_magnitude_out) &&
      $stable(out_angle_out) && $stable(out_saturated)))
    else $error("stalled result changed");

  // a result carries either polar or rectangular fields, never both
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_real_out != '0 || out_imag_out != '0) &&
                    (out_magnitude_out != '0 || out_angle_out != '0)))
    else $error("polar and rectangular fields both set");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_angle_out <= cpr_pkg::PI_Q13) &&
                   (out_angle_out >= -cpr_pkg::PI_Q13)))
    else $error("angle outside of [-pi, pi]");

  a_mag_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated && out_magnitude_out != '0) |->
      (out_magnitude_out == 16'hFFFF))
    else $error("saturated magnitude not at full scale");

endmodule

bind complex_polar_rect_converter cpr_checker u_cpr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_real_out      (out_real_out),
  .out_imag_out      (out_imag_out),
  .out_magnitude_out (out_magnitude_out),
  .out_angle_out     (out_angle_out),
  .out_saturated     (out_saturated)
);
